>>> rtl/asf_pkg.sv
// shared types, constants and helpers of the ascii sentence framer
package asf_pkg;

    localparam int MAX_LEN_DEF  = 64;
    localparam int CNT_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int MIN_EMIT_LEN = 2;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic KIND_DOLLAR = 1'b0;
    localparam logic KIND_HASH   = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DOLLAR,
        MODE_HASH
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic step;    // process the accepted input transaction
        logic rd;      // read store at the read index and advance it
        logic load;    // move read data into the output register
        logic finish;  // sentence fully emitted, back to idle
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit_req;  // the offered transaction ends a sentence worth emitting
        logic last;      // the byte in read data is the final one
        logic out_free;  // output register can take a byte this cycle
    } dp_sts_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, n};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/asf_ram.sv
// generic single write port ram with registered read
module asf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/asf_ctrl.sv
// controller state machine of the ascii sentence framer
module asf_ctrl
    import asf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.emit_req) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.step = s_valid;
            end
            ST_READ: begin
                cmd.rd = 1'b1;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.rd     = !sts.last;
                    cmd.finish = sts.last;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/asf_dp.sv
// datapath of the ascii sentence framer: store, fill level, counters, output register
module asf_dp
    import asf_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic              s_cmd,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_sentence_kind,
    output logic [BYTE_W-1:0] m_text_byte,
    output logic              m_last_byte,
    output logic [CNT_W-1:0]  m_discarded_total,
    output logic [CNT_W-1:0]  m_emitted_total,
    output logic [CNT_W-1:0]  m_overflow_total
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int FILL_W = $clog2(MAX_LEN + 1);

    mode_t             mode_reg, mode_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  disc_reg, disc_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic [CNT_W-1:0]  ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;

    logic              kind_reg;
    logic [BYTE_W-1:0] text_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  disc_out_reg;
    logic [CNT_W-1:0]  emit_out_reg;
    logic [CNT_W-1:0]  ovf_out_reg;

    logic              is_sync, is_term, in_sentence, enough, full;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] rdata;
    logic [FILL_W:0]   fill_plus1;

    assign is_sync     = (s_data_byte == CH_DOLLAR) || (s_data_byte == CH_HASH);
    assign is_term     = (s_data_byte == CH_CR) || (s_data_byte == CH_LF);
    assign in_sentence = (mode_reg != MODE_IDLE);
    assign enough      = (fill_reg >= FILL_W'(MIN_EMIT_LEN));
    assign full        = (fill_reg >= FILL_W'(MAX_LEN));
    assign fill_plus1  = {1'b0, fill_reg} + (FILL_W+1)'(1);

    assign sts.emit_req = (s_cmd == CMD_DATA) && in_sentence && is_term && enough;
    assign sts.last     = (rd_idx_reg == fill_reg);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        disc_next    = disc_reg;
        emit_next    = emit_reg;
        ovf_next     = ovf_reg;
        we           = 1'b0;
        waddr        = fill_reg[ADDR_W-1:0];

        if (cmd.step) begin
            rd_idx_next = '0;
            if (s_cmd == CMD_FLUSH) begin
                mode_next = MODE_IDLE;
                fill_next = '0;
            end else if (!in_sentence) begin
                if (is_sync) begin
                    we        = 1'b1;
                    waddr     = '0;
                    fill_next = FILL_W'(1);
                    mode_next = (s_data_byte == CH_DOLLAR) ? MODE_DOLLAR : MODE_HASH;
                end else begin
                    disc_next = sat_add(disc_reg, CNT_W'(1));
                end
            end else if (is_term) begin
                if (enough) begin
                    // fill and mode stay until the run is out
                    emit_next = sat_add(emit_reg, CNT_W'(1));
                end else begin
                    disc_next = sat_add(disc_reg, CNT_W'(fill_reg));
                    fill_next = '0;
                    mode_next = MODE_IDLE;
                end
            end else if (is_sync) begin
                disc_next = sat_add(disc_reg, CNT_W'(fill_reg));
                we        = 1'b1;
                waddr     = '0;
                fill_next = FILL_W'(1);
                mode_next = (s_data_byte == CH_DOLLAR) ? MODE_DOLLAR : MODE_HASH;
            end else if (full) begin
                ovf_next  = sat_add(ovf_reg, CNT_W'(1));
                disc_next = sat_add(disc_reg, CNT_W'(fill_plus1));
                fill_next = '0;
                mode_next = MODE_IDLE;
            end else begin
                we        = 1'b1;
                fill_next = fill_plus1[FILL_W-1:0];
            end
        end

        if (cmd.rd) begin
            rd_idx_next = rd_idx_reg + FILL_W'(1);
        end

        if (cmd.finish) begin
            fill_next = '0;
            mode_next = MODE_IDLE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            disc_reg    <= '0;
            emit_reg    <= '0;
            ovf_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            disc_reg    <= disc_next;
            emit_reg    <= emit_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= (mode_reg == MODE_DOLLAR) ? KIND_DOLLAR : KIND_HASH;
            text_reg     <= rdata;
            last_reg     <= sts.last;
            disc_out_reg <= disc_reg;
            emit_out_reg <= emit_reg;
            ovf_out_reg  <= ovf_reg;
        end
    end

    asf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_data_byte),
        .re    (cmd.rd),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign m_valid           = m_valid_reg;
    assign m_sentence_kind   = kind_reg;
    assign m_text_byte       = text_reg;
    assign m_last_byte       = last_reg;
    assign m_discarded_total = disc_out_reg;
    assign m_emitted_total   = emit_out_reg;
    assign m_overflow_total  = ovf_out_reg;

endmodule

>>> rtl/ascii_sentence_framer_core.sv
// top level of the ascii sentence framer
// Frames a stream of receiver bytes, one byte per input transaction, into
// '$' and '#' sentences. A sync byte starts a sentence (and restarts one in
// progress, discarding what was gathered), CR or LF ends it, and the stored
// bytes, sync byte first and terminator excluded, come out as a run of result
// transactions with m_last_byte on the final one. Sentences of only the sync
// byte are discarded; sentences longer than MAX_LEN bytes are dropped and
// counted as overflows. Three saturating 32-bit counters (discarded bytes,
// emitted sentences, overflows) ride on every result. A flush command (cmd=1)
// returns framing to idle without touching the counters. An input byte
// that does not end a sentence never holds the input side. A terminator that
// releases a sentence holds the input side while the controller accepts it,
// makes the first read of the sentence store in its read state, then moves
// one byte per cycle through its single registered read port; any m_ready
// stall lengthens the hold. The last result may still wait in the output
// register while the next input transaction is already taken.
module ascii_sentence_framer_core
    import asf_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [BYTE_W-1:0] s_data_byte,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_sentence_kind,
    output logic [BYTE_W-1:0] m_text_byte,
    output logic              m_last_byte,
    output logic [CNT_W-1:0]  m_discarded_total,
    output logic [CNT_W-1:0]  m_emitted_total,
    output logic [CNT_W-1:0]  m_overflow_total
);

    // command and status between controller and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // controller: accepts transactions, sequences the store readout
    asf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: framing mode, fill level, counters, store and output register
    asf_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_cmd             (s_cmd),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sentence_kind   (m_sentence_kind),
        .m_text_byte       (m_text_byte),
        .m_last_byte       (m_last_byte),
        .m_discarded_total (m_discarded_total),
        .m_emitted_total   (m_emitted_total),
        .m_overflow_total  (m_overflow_total)
    );

endmodule

>>> dv/asf_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard with sentence predictor for the ascii sentence framer testbench
package asf_tb_pkg;
    import asf_pkg::*;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] text;
        logic              last;
        logic [CNT_W-1:0]  discarded;
        logic [CNT_W-1:0]  emitted;
        logic [CNT_W-1:0]  overflowed;
    } text_beat_t;

    class framer_scoreboard;
        mode_t             mode;
        logic [BYTE_W-1:0] store [MAX_LEN_DEF];
        int unsigned       fill;
        logic [CNT_W-1:0]  discarded;
        logic [CNT_W-1:0]  emitted;
        logic [CNT_W-1:0]  overflowed;
        text_beat_t        expected_beats [$];
        int                errors;

        function new();
            mode       = MODE_IDLE;
            fill       = 0;
            discarded  = '0;
            emitted    = '0;
            overflowed = '0;
            errors     = 0;
        endfunction

        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] a, input int unsigned n);
            logic [CNT_W:0] s;
            s = {1'b0, a};
            s = s + n;
            return s[CNT_W] ? '1 : s[CNT_W-1:0];
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // frame one accepted input transaction and queue the text beats it releases
        function void note_input(input logic cmd, input logic [BYTE_W-1:0] b);
            text_beat_t beat;
            if (cmd == CMD_FLUSH) begin
                mode = MODE_IDLE;
                fill = 0;
                return;
            end
            if (mode == MODE_IDLE) begin
                if (b == CH_DOLLAR || b == CH_HASH) begin
                    store[0] = b;
                    fill     = 1;
                    mode     = (b == CH_DOLLAR) ? MODE_DOLLAR : MODE_HASH;
                end else begin
                    discarded = bump(discarded, 1);
                end
            end else if (b == CH_CR || b == CH_LF) begin
                if (fill >= MIN_EMIT_LEN) begin
                    emitted = bump(emitted, 1);
                    for (int i = 0; i < fill; i++) begin
                        beat.kind       = (mode == MODE_DOLLAR) ? KIND_DOLLAR : KIND_HASH;
                        beat.text       = store[i];
                        beat.last       = (i + 1 == fill);
                        beat.discarded  = discarded;
                        beat.emitted    = emitted;
                        beat.overflowed = overflowed;
                        expected_beats.insert(expected_beats.size(), beat);
                    end
                end else begin
                    discarded = bump(discarded, fill);
                end
                fill = 0;
                mode = MODE_IDLE;
            end else if (b == CH_DOLLAR || b == CH_HASH) begin
                discarded = bump(discarded, fill);
                store[0]  = b;
                fill      = 1;
                mode      = (b == CH_DOLLAR) ? MODE_DOLLAR : MODE_HASH;
            end else if (fill >= MAX_LEN_DEF) begin
                overflowed = bump(overflowed, 1);
                discarded  = bump(discarded, fill + 1);
                fill       = 0;
                mode       = MODE_IDLE;
            end else begin
                store[fill] = b;
                fill++;
            end
        endfunction

        function void compare(input string field, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic kind, input logic [BYTE_W-1:0] text,
                                   input logic last, input logic [CNT_W-1:0] disc,
                                   input logic [CNT_W-1:0] emit, input logic [CNT_W-1:0] ovf);
            text_beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual text_byte %0h",
                         $time, text);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare("sentence_kind", want.kind, kind);
            compare("text_byte", want.text, text);
            compare("last_byte", want.last, last);
            compare("discarded_total", want.discarded, disc);
            compare("emitted_total", want.emitted, emit);
            compare("overflow_total", want.overflowed, ovf);
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// top-level testbench of the ascii sentence framer: stimulus, handshakes and checking
module tb_top;
    import asf_pkg::*;
    import asf_tb_pkg::*;

    // no-transaction watchdog, long receiver hold-off and drain margin at the end
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int END_WAIT       = MAX_LEN_DEF + 40;

    // how a generated sentence is closed
    typedef enum int {
        END_CR,
        END_LF,
        END_RESYNC,
        END_FLUSH,
        END_OPEN
    } ending_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [BYTE_W-1:0] s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic              m_sentence_kind;
    logic [BYTE_W-1:0] m_text_byte;
    logic              m_last_byte;
    logic [CNT_W-1:0]  m_discarded_total;
    logic [CNT_W-1:0]  m_emitted_total;
    logic [CNT_W-1:0]  m_overflow_total;

    framer_scoreboard sb;

    // idle percentages of the current phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    // request for a long receiver hold-off, picked up by the receiver process
    bit hold_req       = 1'b0;

    ascii_sentence_framer_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sentence_kind   (m_sentence_kind),
        .m_text_byte       (m_text_byte),
        .m_last_byte       (m_last_byte),
        .m_discarded_total (m_discarded_total),
        .m_emitted_total   (m_emitted_total),
        .m_overflow_total  (m_overflow_total)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // offer one input transaction, with a random gap first, and wait for its acceptance
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(cmd, b);
        items_sent++;
    endtask

    // sync byte, body of plain bytes, then the chosen ending
    task automatic send_sentence(input logic [BYTE_W-1:0] sync, input int body_len,
                                 input ending_t ending);
        logic [BYTE_W-1:0] b;
        send_item(CMD_DATA, sync);
        repeat (body_len) begin
            // plain bytes only, so the body neither restarts nor ends the sentence
            do
                b = BYTE_W'($urandom_range(0, 255));
            while (b == CH_DOLLAR || b == CH_HASH || b == CH_CR || b == CH_LF);
            send_item(CMD_DATA, b);
        end
        case (ending)
            END_CR: begin
                send_item(CMD_DATA, CH_CR);
            end
            END_LF: begin
                send_item(CMD_DATA, CH_LF);
            end
            END_FLUSH: begin
                send_item(CMD_FLUSH, BYTE_W'($urandom_range(0, 255)));
            end
            default: begin
                // resync and open endings leave the sentence to whatever follows
            end
        endcase
    endtask

    // mostly well-formed sentences with random content, the rest raw noise
    task automatic run_random(input int quota);
        int               stop_at;
        int               pick;
        int               body;
        ending_t          ending;
        logic [BYTE_W-1:0] sync;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                sync = $urandom_range(0, 1) ? CH_HASH : CH_DOLLAR;
                // a few near or past the store size: full runs and overflows
                if ($urandom_range(0, 99) < 6)
                    body = $urandom_range(MAX_LEN_DEF - 2, MAX_LEN_DEF);
                else
                    body = $urandom_range(0, 10);
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    ending = END_CR;
                else if (pick < 70)
                    ending = END_LF;
                else if (pick < 80)
                    ending = END_RESYNC;
                else if (pick < 90)
                    ending = END_FLUSH;
                else
                    ending = END_OPEN;
                send_sentence(sync, body, ending);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_DATA,
                              BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // sender pauses until every queued text beat has come out
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // main sequence
    initial begin
        sb = new();
        s_valid     <= 1'b0;
        s_cmd       <= CMD_DATA;
        s_data_byte <= '0;
        aresetn     <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: noise and terminators while idle are plain discards
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, CH_LF);
        // short dollar and hash sentences closed by cr and lf
        send_item(CMD_DATA, CH_DOLLAR);
        send_item(CMD_DATA, "G");
        send_item(CMD_DATA, "P");
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, CH_HASH);
        send_item(CMD_DATA, "B");
        send_item(CMD_DATA, "e");
        send_item(CMD_DATA, "S");
        send_item(CMD_DATA, CH_LF);
        // terminator right after the sync byte: nothing comes out
        send_item(CMD_DATA, CH_DOLLAR);
        send_item(CMD_DATA, CH_LF);
        // sync byte in mid-sentence restarts framing as a hash sentence
        send_item(CMD_DATA, CH_DOLLAR);
        send_item(CMD_DATA, "a");
        send_item(CMD_DATA, CH_HASH);
        send_item(CMD_DATA, "z");
        send_item(CMD_DATA, CH_CR);
        // flush in mid-sentence, then flush while idle
        send_item(CMD_DATA, CH_HASH);
        send_item(CMD_DATA, "k");
        send_item(CMD_FLUSH, 8'hFF);
        send_item(CMD_FLUSH, 8'h00);
        wait_drain();

        // phase with no idling at all
        run_random(50);
        wait_drain();

        // receiver holds off while the sender keeps offering: a full-size run,
        // more sentences behind it and an oversize one, so the input side stalls
        hold_req = 1'b1;
        send_sentence(CH_DOLLAR, MAX_LEN_DEF - 1, END_CR);
        send_sentence(CH_HASH, 3, END_LF);
        send_sentence(CH_HASH, MAX_LEN_DEF, END_OPEN);
        send_sentence(CH_DOLLAR, 2, END_CR);
        wait_drain();

        // sender idling
        src_idle_pct   = 64;
        sink_stall_pct = 0;
        run_random(50);
        wait_drain();

        // receiver stalling
        src_idle_pct   = 0;
        sink_stall_pct = 64;
        run_random(50);
        wait_drain();

        // both sides idling
        src_idle_pct   = 29;
        sink_stall_pct = 29;
        run_random(50);
        s_valid <= 1'b0;

        // everything expected must arrive, then nothing more may follow
        wait_drain();
        repeat (END_WAIT) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, or a long counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // every accepted result transaction is checked against the oldest expected beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_sentence_kind, m_text_byte, m_last_byte,
                            m_discarded_total, m_emitted_total, m_overflow_total);
    end

    // watchdog: too many cycles without any transaction on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
